FILE: rtl/core/graf_pkg.sv
// ----------------------------------------------------------------------------
// graf_pkg
// Shared constants, codes and types of the guarded region access filter.
// ----------------------------------------------------------------------------
package graf_pkg;

  localparam int unsigned REGIONS   = 16;
  localparam int unsigned IDX_W     = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int unsigned CNT_W     = $clog2(REGIONS + 1);
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned PROT_W    = 32;
  localparam int unsigned GUARD_BIT = 8;
  localparam int unsigned USE_W     = 5;

  // register indexes, decoded from paddr bit 3
  localparam logic REG_ENABLED    = 1'b0;
  localparam logic REG_OWN_HANDLE = 1'b1;

  typedef enum logic [1:0] {
    MODE_PROTECT = 2'd0,
    MODE_READ    = 2'd1,
    MODE_WRITE   = 2'd2
  } mode_e;

  // item range as held during the table scan
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] length;
    logic [ADDR_W:0]   last;   // base + length, 65 bits
  } item_t;

  typedef struct packed {
    logic same;      // entry has exactly the item's start and length
    logic overlap;   // entry range meets the item range
  } hit_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
  } mem_wr_t;

  function automatic logic [USE_W-1:0] sat_count(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+USE_W-1:0] wide;
    wide = (CNT_W + USE_W)'(cnt);
    if (wide > (CNT_W + USE_W)'((1 << USE_W) - 1)) begin
      return '1;
    end
    return wide[USE_W-1:0];
  endfunction

endpackage

FILE: rtl/core/guarded_region_access_filter.sv
// ----------------------------------------------------------------------------
// guarded_region_access_filter
// Table of guarded address ranges that filters read and write accesses and
// takes guard inserts and removals from protection changes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request word: tuser = mode, tdata = handle, base,
//   length and new protection. m_axis returns one result word per request:
//   denied, insert_dropped and the number of regions in use.
//   APB registers: enabled at 0x0, own process handle at 0x8 (64 bits).
//   A request is taken only while the sequencer is idle. A read, write or
//   guard removal scans the table one entry per cycle through a single
//   memory read port and one compare unit, then registers the result word.
//   A guard insert and an ignored request skip the scan. The next
//   request can be accepted the cycle after the result is loaded into the
//   output register, so a new request is never taken before the last one
//   is through.
//   If the receiver stalls, the result waits in the output register; a
//   further finished request then holds in its last step until it drains.
//   Reset empties the table (valid bits cleared), sets enabled to 1 and the
//   own handle to 0. No clearing pass is needed.
// ----------------------------------------------------------------------------
module guarded_region_access_filter (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request channel
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [223:0] s_axis_tdata,  // process_handle, base_address, length, new_protect
  input  logic [1:0]   s_axis_tuser,  // mode
  // result channel
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,  // denied, insert_dropped, regions_in_use, pad
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_INSERT = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  localparam logic [graf_pkg::IDX_W-1:0] LAST_IDX = graf_pkg::IDX_W'(graf_pkg::REGIONS - 1);

  state_e                           state_q, state_d;
  logic                             enabled_q;
  logic [graf_pkg::ADDR_W-1:0]      own_handle_q;
  logic [graf_pkg::REGIONS-1:0]     valid_q;
  logic [graf_pkg::CNT_W-1:0]       cnt_q;
  logic [graf_pkg::IDX_W-1:0]       scan_idx_q;
  logic [graf_pkg::IDX_W-1:0]       cmp_idx_q;
  logic                             cmp_vld_q;
  logic                             op_remove_q;
  logic                             denied_q;
  logic                             dropped_q;
  logic                             out_vld_q;
  logic [7:0]                       out_data_q;
  graf_pkg::item_t                  item_q;

  graf_pkg::mode_e                  in_mode;
  logic [graf_pkg::ADDR_W-1:0]      in_handle;
  logic [graf_pkg::ADDR_W-1:0]      in_base;
  logic [graf_pkg::ADDR_W-1:0]      in_length;
  logic [graf_pkg::PROT_W-1:0]      in_prot;
  logic                             in_own;
  logic                             in_fire;
  logic                             out_load;
  logic                             cfg_wr;
  logic                             free_any;
  logic [graf_pkg::IDX_W-1:0]       free_idx;
  logic                             entry_live;
  graf_pkg::mem_wr_t                mem_wr;
  graf_pkg::hit_t                   hit;
  logic [graf_pkg::ADDR_W-1:0]      rd_start;
  logic [graf_pkg::ADDR_W-1:0]      rd_length;

  assign in_mode   = graf_pkg::mode_e'(s_axis_tuser);
  assign in_handle = s_axis_tdata[63:0];
  assign in_base   = s_axis_tdata[127:64];
  assign in_length = s_axis_tdata[191:128];
  assign in_prot   = s_axis_tdata[223:192];
  assign in_own    = (in_handle == own_handle_q) || (in_handle == '0) || (in_handle == '1);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!out_vld_q || m_axis_tready);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == graf_pkg::REG_OWN_HANDLE) ? own_handle_q
                                                          : {63'd0, enabled_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q    <= 1'b1;
      own_handle_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == graf_pkg::REG_OWN_HANDLE) begin
        own_handle_q <= pwdata;
      end else begin
        enabled_q <= pwdata[0];
      end
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = graf_pkg::REGIONS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = graf_pkg::IDX_W'(i);
      end
    end
  end
  assign free_any = ~&valid_q;

  assign mem_wr.en     = (state_q == S_INSERT) && free_any;
  assign mem_wr.addr   = free_idx;
  assign mem_wr.start  = item_q.base;
  assign mem_wr.length = item_q.length;

  graf_region_mem u_mem (
    .clk_i       (clk_i),
    .wr_i        (mem_wr),
    .rd_addr_i   (scan_idx_q),
    .rd_start_o  (rd_start),
    .rd_length_o (rd_length)
  );

  graf_range_unit u_range (
    .item_i         (item_q),
    .entry_start_i  (rd_start),
    .entry_length_i (rd_length),
    .hit_o          (hit)
  );

  assign entry_live = cmp_vld_q && valid_q[cmp_idx_q];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_DONE;
          if (enabled_q) begin
            case (in_mode)
              graf_pkg::MODE_PROTECT: begin
                if (in_own) begin
                  state_d = in_prot[graf_pkg::GUARD_BIT] ? S_INSERT : S_SCAN;
                end
              end
              graf_pkg::MODE_READ,
              graf_pkg::MODE_WRITE: state_d = S_SCAN;
              default: state_d = S_DONE;
            endcase
          end
        end
      end
      S_INSERT: state_d = S_DONE;
      S_SCAN: begin
        if (scan_idx_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      cnt_q       <= '0;
      scan_idx_q  <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      op_remove_q <= 1'b0;
      denied_q    <= 1'b0;
      dropped_q   <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == S_SCAN);
      cmp_idx_q <= scan_idx_q;

      if (in_fire) begin
        denied_q    <= 1'b0;
        dropped_q   <= 1'b0;
        scan_idx_q  <= '0;
        op_remove_q <= (in_mode == graf_pkg::MODE_PROTECT);
      end else if (state_q == S_SCAN) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end

      if (state_q == S_INSERT) begin
        if (free_any) begin
          valid_q[free_idx] <= 1'b1;
          cnt_q             <= cnt_q + 1'b1;
        end else begin
          dropped_q <= 1'b1;
        end
      end

      // one entry per cycle through the compare unit
      if (entry_live) begin
        if (op_remove_q) begin
          if (hit.same) begin
            valid_q[cmp_idx_q] <= 1'b0;
            cnt_q              <= cnt_q - 1'b1;
          end
        end else if (hit.overlap) begin
          denied_q <= 1'b1;
        end
      end

      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.base   <= in_base;
      item_q.length <= in_length;
      item_q.last   <= {1'b0, in_base} + {1'b0, in_length};
    end
    if (out_load) begin
      out_data_q <= {1'b0, graf_pkg::sat_count(cnt_q), dropped_q, denied_q};
    end
  end

endmodule

FILE: rtl/core/graf_region_mem.sv
// ----------------------------------------------------------------------------
// graf_region_mem
// Start and length store of the region table, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module graf_region_mem (
  input  logic                          clk_i,
  input  graf_pkg::mem_wr_t             wr_i,
  input  logic [graf_pkg::IDX_W-1:0]    rd_addr_i,
  output logic [graf_pkg::ADDR_W-1:0]   rd_start_o,
  output logic [graf_pkg::ADDR_W-1:0]   rd_length_o
);

  logic [graf_pkg::ADDR_W-1:0] start_mem  [graf_pkg::REGIONS];
  logic [graf_pkg::ADDR_W-1:0] length_mem [graf_pkg::REGIONS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      start_mem[wr_i.addr]  <= wr_i.start;
      length_mem[wr_i.addr] <= wr_i.length;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_start_o  <= start_mem[rd_addr_i];
    rd_length_o <= length_mem[rd_addr_i];
  end

endmodule

FILE: rtl/core/graf_range_unit.sv
// ----------------------------------------------------------------------------
// graf_range_unit
// Shared compare unit: checks one table entry against the current item for
// exact match and for overlap, with 65-bit range ends.
// ----------------------------------------------------------------------------
module graf_range_unit (
  input  graf_pkg::item_t               item_i,
  input  logic [graf_pkg::ADDR_W-1:0]   entry_start_i,
  input  logic [graf_pkg::ADDR_W-1:0]   entry_length_i,
  output graf_pkg::hit_t                hit_o
);

  logic [graf_pkg::ADDR_W:0] entry_last;
  logic                      item_before;
  logic                      item_after;

  assign entry_last  = {1'b0, entry_start_i} + {1'b0, entry_length_i};
  // a carry out of the item end keeps it above any start
  assign item_before = item_i.last <= {1'b0, entry_start_i};
  assign item_after  = {1'b0, item_i.base} >= entry_last;

  assign hit_o.overlap = !(item_before || item_after);
  assign hit_o.same    = (entry_start_i == item_i.base) && (entry_length_i == item_i.length);

endmodule

FILE: rtl/core/graf_checker.sv
// ----------------------------------------------------------------------------
// graf_checker
// Port-level checks of the guarded region access filter, bound to the top.
// ----------------------------------------------------------------------------
module graf_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [7:0]   m_axis_tdata
);

  // one request at a time: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while previous one in work");

  // a result never reports both a denial and a dropped insert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("denied and insert_dropped both set");

  // count never exceeds the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(m_axis_tdata[6:2]) <= graf_pkg::REGIONS))
    else $error("regions_in_use above table size");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind guarded_region_access_filter graf_checker u_graf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
